@@ design/sbo_pkg.sv @@
// ----------------------------------------------------------------------------
// sbo_pkg: shared types and constants for the sphere/box overlap test
// Field widths, datapath widths and the control word of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbo_pkg;

  // field widths
  localparam int POSITION_BITS = 32;
  localparam int SCALE_BITS    = 16;
  localparam int EXT_BITS      = 31;

  // scaled extent: ext * scale
  localparam int H_W    = EXT_BITS + SCALE_BITS;
  // centre distance at doubled Q.24 scale
  localparam int C_W    = POSITION_BITS + 9;
  // width of every value that gets squared
  localparam int SQ_W   = (H_W + 1 > C_W) ? H_W + 1 : C_W;
  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int HI_W   = SQ_W - MUL_W;
  // signed accumulator: three squares minus one square
  localparam int ACC_W  = 2 * SQ_W + 3;

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic [POSITION_BITS-1:0]        dist_t;
  typedef logic [SCALE_BITS-1:0]           scale_t;
  typedef logic [EXT_BITS-1:0]             ext_t;
  typedef logic [H_W-1:0]                  h_t;
  typedef logic [SQ_W-1:0]                 sq_t;
  typedef logic [MUL_W-1:0]                mul_t;
  typedef logic [PROD_W-1:0]               prod_t;
  typedef logic signed [ACC_W-1:0]         acc_t;

  typedef enum logic [1:0] {
    OP_STORE_SPHERE = 2'd0,
    OP_STORE_BOX    = 2'd1,
    OP_TEST_SPHERE  = 2'd2,
    OP_TEST_BOX     = 2'd3
  } opcode_t;

  // weight of a partial product inside the accumulator
  typedef enum logic [1:0] {
    SHIFT_NONE  = 2'd0,
    SHIFT_WORD  = 2'd1,
    SHIFT_DWORD = 2'd2
  } shift_t;

  // control word from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic   issue;    // load the product register
    logic   acc_en;   // add the product into the accumulator next cycle
    logic   acc_clr;  // clear the accumulator
    shift_t shift;
    logic   dbl;      // cross term, counted twice
    logic   neg;      // subtract instead of add
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ design/sbo_item_if.sv @@
// ----------------------------------------------------------------------------
// sbo_item_if: input word channel
// One object description plus the opcode, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbo_item_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  sbo_pkg::pos_t        pos_x;
  sbo_pkg::pos_t        pos_y;
  sbo_pkg::pos_t        pos_z;
  sbo_pkg::scale_t      scale_x;
  sbo_pkg::scale_t      scale_y;
  sbo_pkg::scale_t      scale_z;
  sbo_pkg::ext_t        ext_x;
  sbo_pkg::ext_t        ext_y;
  sbo_pkg::ext_t        ext_z;

  modport source (
    output valid, opcode, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
           ext_x, ext_y, ext_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
           ext_x, ext_y, ext_z,
    output ready
  );
endinterface

`default_nettype wire

@@ design/sbo_result_if.sv @@
// ----------------------------------------------------------------------------
// sbo_result_if: result word channel
// Overlap flag and missing-first-object flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbo_result_if;
  logic valid;
  logic ready;
  logic collides;
  logic first_missing;

  modport source (
    output valid, collides, first_missing,
    input  ready
  );
  modport sink (
    input  valid, collides, first_missing,
    output ready
  );
endinterface

`default_nettype wire

@@ design/sbo_mac.sv @@
// ----------------------------------------------------------------------------
// sbo_mac: shared multiplier with signed accumulator
// 32x32 unsigned multiply into a product register, then a weighted
// add or subtract of that product into the accumulator in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbo_mac (
  input  logic               clk,
  input  logic               rst,
  input  sbo_pkg::mac_ctl_t  ctl,
  input  sbo_pkg::mul_t      a,
  input  sbo_pkg::mul_t      b,
  output sbo_pkg::prod_t     prod,
  output sbo_pkg::acc_t      acc
);

  logic             stage_en;
  sbo_pkg::shift_t  stage_shift;
  logic             stage_dbl;
  logic             stage_neg;
  sbo_pkg::acc_t    term;
  sbo_pkg::acc_t    prod_ext;

  // staged control, aligned with the product register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_en <= 1'b0;
    end else begin
      stage_en <= ctl.issue & ctl.acc_en;
    end
  end

  // product register and staged weighting
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod        <= a * b;
      stage_shift <= ctl.shift;
      stage_dbl   <= ctl.dbl;
      stage_neg   <= ctl.neg;
    end
  end

  // weight the product by its position in the square
  always_comb begin
    prod_ext = sbo_pkg::acc_t'(prod);
    case (stage_shift)
      sbo_pkg::SHIFT_NONE:  term = prod_ext;
      sbo_pkg::SHIFT_WORD:  term = prod_ext << sbo_pkg::MUL_W;
      sbo_pkg::SHIFT_DWORD: term = prod_ext << (2 * sbo_pkg::MUL_W);
      default:              term = prod_ext;
    endcase
    if (stage_dbl) begin
      term = term << 1;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (stage_en) begin
      acc <= stage_neg ? acc - term : acc + term;
    end
  end

endmodule

`default_nettype wire

@@ design/sphere_box_overlap_test.sv @@
// ----------------------------------------------------------------------------
// sphere_box_overlap_test: overlap test of a stored object against a given one
// A store word gives no result; every test answers with one result word,
// also when no object is stored. The block takes no new word until that
// result is loaded. A test with a stored object uses the one shared 32x32
// multiplier for six extent*scale products; any pair with a sphere then also
// takes three partial products for each of four 48-bit squares.
// Reset (synchronous, active high) forgets the stored object and drops
// any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_box_overlap_test (
  input  logic        clk,
  input  logic        rst,
  sbo_item_if.sink    item,
  sbo_result_if.source result
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXT, ST_PREP, ST_SQUARE, ST_DRAIN, ST_DONE
  } state_t;

  // which test applies to the stored and the given object
  typedef enum logic [1:0] {
    PAIR_SS,  // two spheres
    PAIR_BB,  // two boxes
    PAIR_BF,  // box stored, sphere given
    PAIR_SF   // sphere stored, box given
  } pair_t;

  // sub-steps of one square and the slot of the threshold value
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HH = 2'd2;
  localparam logic [1:0] SLOT_T  = 2'd3;
  localparam logic [3:0] EXT_LAST  = 4'd5;
  localparam logic [3:0] PREP_LAST = 4'd2;
  localparam logic [3:0] SQ_LAST   = {SLOT_T, PART_HH};

  state_t state;
  logic [3:0] cnt;
  pair_t pair;
  logic missing;
  logic first_loaded;
  logic first_is_box;
  logic out_valid;
  logic out_collides;
  logic out_first_missing;
  logic wb_valid;
  logic [2:0] wb_idx;

  sbo_pkg::pos_t   first_pos [0:2];
  sbo_pkg::scale_t first_scl [0:2];
  sbo_pkg::ext_t   first_ext [0:2];
  sbo_pkg::pos_t   g_pos [0:2];
  sbo_pkg::scale_t g_scl [0:2];
  sbo_pkg::ext_t   g_ext [0:2];
  sbo_pkg::dist_t  d [0:2];
  sbo_pkg::h_t     h_f [0:2];
  sbo_pkg::h_t     h_g [0:2];
  sbo_pkg::sq_t    v [0:2];
  sbo_pkg::sq_t    t;
  logic            bb_ok;

  sbo_pkg::mac_ctl_t mac_ctl;
  sbo_pkg::mul_t     mul_a;
  sbo_pkg::mul_t     mul_b;
  sbo_pkg::prod_t    prod;
  sbo_pkg::acc_t     acc;

  logic        accept;
  logic [1:0]  mul_ax;
  logic [1:0]  d_ax;
  logic [1:0]  j;
  logic [1:0]  slot;
  logic [1:0]  part;
  sbo_pkg::sq_t sq_x;
  logic signed [sbo_pkg::POSITION_BITS:0] diff_fg;
  logic signed [sbo_pkg::POSITION_BITS:0] diff_gf;
  sbo_pkg::dist_t d_new;
  sbo_pkg::sq_t c_sh9;
  sbo_pkg::sq_t c_sh8;
  sbo_pkg::sq_t hb;
  sbo_pkg::sq_t hs0;
  sbo_pkg::sq_t span;
  sbo_pkg::sq_t v_new;
  sbo_pkg::sq_t t_new;
  logic        bb_axis_ok;
  logic        hit;
  logic        store_op;
  logic        given_box;

  assign accept    = item.valid & item.ready;
  assign item.ready = (state == ST_IDLE);
  assign store_op  = (item.opcode == sbo_pkg::OP_STORE_SPHERE) ||
                     (item.opcode == sbo_pkg::OP_STORE_BOX);
  assign given_box = (item.opcode == sbo_pkg::OP_STORE_BOX) ||
                     (item.opcode == sbo_pkg::OP_TEST_BOX);

  assign result.valid         = out_valid;
  assign result.collides      = out_collides;
  assign result.first_missing = out_first_missing;

  assign mul_ax = cnt[2:1];
  assign d_ax   = cnt[1:0];
  assign j      = cnt[1:0];
  assign slot   = cnt[3:2];
  assign part   = cnt[1:0];

  // absolute centre distance on one axis
  always_comb begin
    diff_fg = {first_pos[d_ax][sbo_pkg::POSITION_BITS-1], first_pos[d_ax]} -
              {g_pos[d_ax][sbo_pkg::POSITION_BITS-1], g_pos[d_ax]};
    diff_gf = {g_pos[d_ax][sbo_pkg::POSITION_BITS-1], g_pos[d_ax]} -
              {first_pos[d_ax][sbo_pkg::POSITION_BITS-1], first_pos[d_ax]};
    d_new   = diff_fg[sbo_pkg::POSITION_BITS] ?
              diff_gf[sbo_pkg::POSITION_BITS-1:0] :
              diff_fg[sbo_pkg::POSITION_BITS-1:0];
  end

  // per-axis values to square, threshold and box-box axis check
  always_comb begin
    c_sh9 = sbo_pkg::sq_t'(d[j]) << 9;
    c_sh8 = sbo_pkg::sq_t'(d[j]) << 8;
    hb    = (pair == PAIR_BF) ? sbo_pkg::sq_t'(h_f[j]) : sbo_pkg::sq_t'(h_g[j]);
    hs0   = (pair == PAIR_BF) ? sbo_pkg::sq_t'(h_g[0]) : sbo_pkg::sq_t'(h_f[0]);
    span  = sbo_pkg::sq_t'(h_f[j]) + sbo_pkg::sq_t'(h_g[j]);
    bb_axis_ok = (c_sh9 <= span);
    if (pair == PAIR_SS) begin
      v_new = c_sh8;
      t_new = sbo_pkg::sq_t'(h_f[0]) + sbo_pkg::sq_t'(h_g[0]);
    end else begin
      v_new = (c_sh9 > hb) ? c_sh9 - hb : '0;
      t_new = hs0 << 1;
    end
  end

  // sequencer drive of the shared multiplier
  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    sq_x    = (slot == SLOT_T) ? t : v[slot];
    unique case (state)
      ST_EXT: begin
        mac_ctl.issue = 1'b1;
        if (cnt[0]) begin
          mul_a = sbo_pkg::mul_t'(g_ext[mul_ax]);
          mul_b = sbo_pkg::mul_t'(g_scl[mul_ax]);
        end else begin
          mul_a = sbo_pkg::mul_t'(first_ext[mul_ax]);
          mul_b = sbo_pkg::mul_t'(first_scl[mul_ax]);
        end
      end
      ST_PREP: begin
        mac_ctl.acc_clr = (cnt == PREP_LAST);
      end
      ST_SQUARE: begin
        mac_ctl.issue  = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mac_ctl.neg    = (slot == SLOT_T);
        unique case (part)
          PART_LL: begin
            mul_a = sq_x[sbo_pkg::MUL_W-1:0];
            mul_b = sq_x[sbo_pkg::MUL_W-1:0];
            mac_ctl.shift = sbo_pkg::SHIFT_NONE;
          end
          PART_LH: begin
            mul_a = sq_x[sbo_pkg::MUL_W-1:0];
            mul_b = sbo_pkg::mul_t'(sq_x[sbo_pkg::SQ_W-1:sbo_pkg::MUL_W]);
            mac_ctl.shift = sbo_pkg::SHIFT_WORD;
            mac_ctl.dbl   = 1'b1;
          end
          default: begin
            mul_a = sbo_pkg::mul_t'(sq_x[sbo_pkg::SQ_W-1:sbo_pkg::MUL_W]);
            mul_b = sbo_pkg::mul_t'(sq_x[sbo_pkg::SQ_W-1:sbo_pkg::MUL_W]);
            mac_ctl.shift = sbo_pkg::SHIFT_DWORD;
          end
        endcase
      end
      default: ;
    endcase
  end

  sbo_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod),
    .acc  (acc)
  );

  // final decision
  always_comb begin
    unique case (pair)
      PAIR_SS: hit = acc[sbo_pkg::ACC_W-1] || (acc == '0);
      PAIR_BB: hit = bb_ok;
      default: hit = acc[sbo_pkg::ACC_W-1];
    endcase
  end

  // state machine, stored-object flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cnt               <= '0;
      pair              <= PAIR_SS;
      missing           <= 1'b0;
      first_loaded      <= 1'b0;
      first_is_box      <= 1'b0;
      out_valid         <= 1'b0;
      out_collides      <= 1'b0;
      out_first_missing <= 1'b0;
      wb_valid          <= 1'b0;
      wb_idx            <= '0;
    end else begin
      // result word taken; the done state does its own handoff
      if (result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      wb_valid <= (state == ST_EXT);
      wb_idx   <= cnt[2:0];
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_op) begin
              first_loaded <= 1'b1;
              first_is_box <= given_box;
            end else if (!first_loaded) begin
              missing <= 1'b1;
              state   <= ST_DONE;
            end else begin
              missing <= 1'b0;
              cnt     <= '0;
              state   <= ST_EXT;
              if (first_is_box && given_box) begin
                pair <= PAIR_BB;
              end else if (first_is_box) begin
                pair <= PAIR_BF;
              end else if (given_box) begin
                pair <= PAIR_SF;
              end else begin
                pair <= PAIR_SS;
              end
            end
          end
        end
        ST_EXT: begin
          if (cnt == EXT_LAST) begin
            cnt   <= '0;
            state <= ST_PREP;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_PREP: begin
          if (cnt == PREP_LAST) begin
            cnt   <= '0;
            state <= (pair == PAIR_BB) ? ST_DONE : ST_SQUARE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_SQUARE: begin
          if (cnt == SQ_LAST) begin
            state <= ST_DRAIN;
          end else if (part == PART_HH) begin
            cnt <= {slot + 2'd1, PART_LL};
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid         <= 1'b1;
            out_collides      <= missing ? 1'b0 : hit;
            out_first_missing <= missing;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // object registers and per-test working values
  always_ff @(posedge clk) begin
    if (accept && store_op) begin
      first_pos[0] <= item.pos_x;
      first_pos[1] <= item.pos_y;
      first_pos[2] <= item.pos_z;
      first_scl[0] <= item.scale_x;
      first_scl[1] <= item.scale_y;
      first_scl[2] <= item.scale_z;
      first_ext[0] <= item.ext_x;
      first_ext[1] <= item.ext_y;
      first_ext[2] <= item.ext_z;
    end
    if (accept && !store_op) begin
      g_pos[0] <= item.pos_x;
      g_pos[1] <= item.pos_y;
      g_pos[2] <= item.pos_z;
      g_scl[0] <= item.scale_x;
      g_scl[1] <= item.scale_y;
      g_scl[2] <= item.scale_z;
      g_ext[0] <= item.ext_x;
      g_ext[1] <= item.ext_y;
      g_ext[2] <= item.ext_z;
    end
    // centre distances while the extent products run
    if (state == ST_EXT && cnt <= PREP_LAST) begin
      d[d_ax] <= d_new;
    end
    // scaled extents from the product register
    if (wb_valid) begin
      if (wb_idx[0]) begin
        h_g[wb_idx[2:1]] <= prod[sbo_pkg::H_W-1:0];
      end else begin
        h_f[wb_idx[2:1]] <= prod[sbo_pkg::H_W-1:0];
      end
    end
    // per-axis preparation
    if (state == ST_PREP) begin
      v[j]  <= v_new;
      bb_ok <= ((j == 2'd0) ? 1'b1 : bb_ok) & bb_axis_ok;
      if (j == 2'd0) begin
        t <= t_new;
      end
    end
  end

  // a result appears only out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result loaded outside the done state");

  // a store word records the object and starts no test
  a_store_no_test: assert property (@(posedge clk) disable iff (rst)
    (accept && store_op) |=> (first_loaded && state == ST_IDLE))
    else $error("store word did not settle back to idle");

  // missing object never reports a hit
  a_missing_no_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_first_missing) |-> !out_collides)
    else $error("hit reported with no stored object");

  // box-box needs no squares
  a_bb_no_square: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQUARE) |-> (pair != PAIR_BB))
    else $error("box-box pair entered the square phase");

  // extent writeback follows an extent product
  a_wb_after_ext: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> $past(state == ST_EXT))
    else $error("extent writeback without a product");

endmodule

`default_nettype wire
